/* sv/srtp_pkg.sv */
// Shared types and constants for the scale, rotate and translate pipeline.
`timescale 1ns / 1ps
package srtp_pkg;

  localparam logic [1:0] REG_SCALES = 2'd0;
  localparam logic [1:0] REG_QUAT   = 2'd1;
  localparam logic [1:0] REG_OFFSET = 2'd2;

  localparam logic [47:0] SCALES_RESET = 48'h1000_1000_1000;
  localparam logic [63:0] QUAT_RESET   = 64'h4000_0000_0000_0000;
  localparam logic [47:0] OFFSET_RESET = 48'h0;

  typedef logic signed [15:0] coef_t;
  typedef logic signed [19:0] vfix_t;
  typedef logic signed [23:0] tfix_t;
  typedef logic signed [27:0] sfix_t;

  typedef struct packed {
    logic               mode;
    logic signed [15:0] in_x;
    logic signed [15:0] in_y;
    logic signed [15:0] in_z;
  } pt_in_t;

  typedef struct packed {
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
    logic signed [15:0] out_z;
    logic               saturated;
  } pt_out_t;

  typedef struct packed {
    logic valid;
    logic point;
  } ctl_t;

endpackage

/* sv/scale_rotate_translate_point.sv */
// Top level: configuration registers and the seven-stage transform pipeline.
`timescale 1ns / 1ps
// Transforms one Q8.8 point or direction per clock: per-axis Q4.12 scale,
// Q1.14 quaternion rotation, then translation in point mode, with each
// component saturated to 16 bits. A request is taken whenever start is high;
// busy is always low. The result appears on result with result_valid high for
// one cycle, after the pipeline stages in order (scale multiply and round,
// cross multiply and round, rotate multiply and sum, clamp). The receiver
// cannot stall, so results are never held. Configuration writes are always
// ready and take effect at once, also on requests still in the pipeline.
module scale_rotate_translate_point import srtp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  pt_in_t      req,
  output logic        result_valid,
  output pt_out_t     result,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  logic [47:0] axis_scales;
  logic [63:0] rotation_quat;
  logic [47:0] offset_xyz;

  coef_t scale [3];
  coef_t qv [3];
  coef_t off [3];
  coef_t w;

  ctl_t  ctl_s, ctl_c, ctl_r;
  vfix_t v_s [3];
  vfix_t v_c [3];
  vfix_t v_r [3];
  tfix_t t_c [3];
  sfix_t s_r [3];

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      axis_scales   <= SCALES_RESET;
      rotation_quat <= QUAT_RESET;
      offset_xyz    <= OFFSET_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SCALES: axis_scales   <= cfg_data[47:0];
        REG_QUAT:   rotation_quat <= cfg_data;
        REG_OFFSET: offset_xyz    <= cfg_data[47:0];
        default: begin
        end
      endcase
    end
  end

  assign w = rotation_quat[63:48];

  for (genvar i = 0; i < 3; i++) begin : g_lane
    assign scale[i] = axis_scales[47 - 16 * i -: 16];
    assign qv[i]    = rotation_quat[47 - 16 * i -: 16];
    assign off[i]   = offset_xyz[47 - 16 * i -: 16];
  end

  srtp_scale u_scale (
    .clk      (clk),
    .rst      (rst),
    .in_valid (start && !busy),
    .req      (req),
    .scale    (scale),
    .ctl      (ctl_s),
    .v        (v_s)
  );

  srtp_cross u_cross (
    .clk    (clk),
    .rst    (rst),
    .ctl_in (ctl_s),
    .v_in   (v_s),
    .qv     (qv),
    .ctl    (ctl_c),
    .v      (v_c),
    .t      (t_c)
  );

  srtp_rotate u_rotate (
    .clk    (clk),
    .rst    (rst),
    .ctl_in (ctl_c),
    .v_in   (v_c),
    .t_in   (t_c),
    .qv     (qv),
    .w      (w),
    .ctl    (ctl_r),
    .v      (v_r),
    .s      (s_r)
  );

  srtp_clamp u_clamp (
    .clk          (clk),
    .rst          (rst),
    .ctl_in       (ctl_r),
    .v_in         (v_r),
    .s_in         (s_r),
    .off          (off),
    .result_valid (result_valid),
    .result       (result)
  );

  a_valid_from_request: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(start && !busy, 7))
    else $error("result without a request seven cycles earlier");

  a_sat_at_limit: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.saturated) |->
      (result.out_x == 16'sh7FFF || result.out_x == -16'sh8000 ||
       result.out_y == 16'sh7FFF || result.out_y == -16'sh8000 ||
       result.out_z == 16'sh7FFF || result.out_z == -16'sh8000))
    else $error("saturated flag with no component at a limit");

  a_valid_reset_chain: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result strobe directly after reset");

endmodule

/* sv/srtp_scale.sv */
// Per-axis scaling: multiply stage and rounding stage.
`timescale 1ns / 1ps
module srtp_scale import srtp_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  input  pt_in_t req,
  input  coef_t  scale [3],
  output ctl_t   ctl,
  output vfix_t  v [3]
);

  ctl_t               ctl1;
  coef_t              x [3];
  logic signed [31:0] prod [3];

  assign x[0] = req.in_x;
  assign x[1] = req.in_y;
  assign x[2] = req.in_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1 <= '0;
      ctl  <= '0;
    end else begin
      ctl1 <= '{valid: in_valid, point: !req.mode};
      ctl  <= ctl1;
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_lane
    always_ff @(posedge clk) begin
      prod[i] <= x[i] * scale[i];
      v[i]    <= vfix_t'((prod[i] + 32'sd2048) >>> 12);
    end
  end

endmodule

/* sv/srtp_cross.sv */
// Doubled cross product t = 2 (qv x v): multiply stage and rounding stage.
`timescale 1ns / 1ps
module srtp_cross import srtp_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  ctl_t  ctl_in,
  input  vfix_t v_in [3],
  input  coef_t qv [3],
  output ctl_t  ctl,
  output vfix_t v [3],
  output tfix_t t [3]
);

  ctl_t               ctl1;
  vfix_t              v1 [3];
  logic signed [35:0] pa [3];
  logic signed [35:0] pb [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1 <= '0;
      ctl  <= '0;
    end else begin
      ctl1 <= ctl_in;
      ctl  <= ctl1;
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_lane
    localparam int A = (i + 1) % 3;
    localparam int B = (i + 2) % 3;
    always_ff @(posedge clk) begin
      pa[i] <= qv[A] * v_in[B];
      pb[i] <= qv[B] * v_in[A];
      v1[i] <= v_in[i];
      t[i]  <= tfix_t'((37'(pa[i]) - 37'(pb[i]) + 37'sd4096) >>> 13);
      v[i]  <= v1[i];
    end
  end

endmodule

/* sv/srtp_rotate.sv */
// Rotation term (w t + qv x t) / 2^14: multiply stage and sum/round stage.
`timescale 1ns / 1ps
module srtp_rotate import srtp_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  ctl_t  ctl_in,
  input  vfix_t v_in [3],
  input  tfix_t t_in [3],
  input  coef_t qv [3],
  input  coef_t w,
  output ctl_t  ctl,
  output vfix_t v [3],
  output sfix_t s [3]
);

  ctl_t               ctl1;
  vfix_t              v1 [3];
  logic signed [39:0] wt [3];
  logic signed [39:0] da [3];
  logic signed [39:0] db [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1 <= '0;
      ctl  <= '0;
    end else begin
      ctl1 <= ctl_in;
      ctl  <= ctl1;
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_lane
    localparam int A = (i + 1) % 3;
    localparam int B = (i + 2) % 3;
    always_ff @(posedge clk) begin
      wt[i] <= w * t_in[i];
      da[i] <= qv[A] * t_in[B];
      db[i] <= qv[B] * t_in[A];
      v1[i] <= v_in[i];
      s[i]  <= sfix_t'((42'(wt[i]) + 42'(da[i]) - 42'(db[i]) + 42'sd8192) >>> 14);
      v[i]  <= v1[i];
    end
  end

endmodule

/* sv/srtp_clamp.sv */
// Final sum, optional translation, saturation and result register.
`timescale 1ns / 1ps
module srtp_clamp import srtp_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  ctl_t    ctl_in,
  input  vfix_t   v_in [3],
  input  sfix_t   s_in [3],
  input  coef_t   off [3],
  output logic    result_valid,
  output pt_out_t result
);

  logic signed [29:0] r [3];
  coef_t              q [3];
  logic [2:0]         clip;
  pt_out_t            result_next;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      r[i] = 30'(v_in[i]) + 30'(s_in[i]) + (ctl_in.point ? 30'(off[i]) : 30'sd0);
      if (r[i] > 30'sd32767) begin
        q[i]    = 16'sh7FFF;
        clip[i] = 1'b1;
      end else if (r[i] < -30'sd32768) begin
        q[i]    = -16'sh8000;
        clip[i] = 1'b1;
      end else begin
        q[i]    = coef_t'(r[i]);
        clip[i] = 1'b0;
      end
    end
    result_next = '{out_x: q[0], out_y: q[1], out_z: q[2], saturated: |clip};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= ctl_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the scale, rotate and translate point pipeline.
`timescale 1ns / 1ps
module tb_top;
  import srtp_pkg::*;

  localparam logic [1:0] REG_NONE   = 2'd3;
  localparam logic       MODE_POINT = 1'b0;
  localparam logic       MODE_DIR   = 1'b1;
  localparam int         LATENCY    = 7;

  typedef longint triple_t [3];

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  pt_in_t      req = '0;
  logic        result_valid;
  pt_out_t     result;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = REG_SCALES;
  logic [63:0] cfg_data = '0;

  logic [47:0] scales_q = SCALES_RESET;
  logic [63:0] quat_q   = QUAT_RESET;
  logic [47:0] offset_q = OFFSET_RESET;
  pt_out_t     expected_points [$];
  int          mismatch_count = 0;
  int          gap_pct = 0;

  scale_rotate_translate_point dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .req(req),
    .result_valid(result_valid),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint round_shift(input longint a, input int n);
    return (a + (longint'(1) << (n - 1))) >>> n;
  endfunction

  function automatic void cross3(input triple_t a, input triple_t b, output triple_t r);
    r[0] = a[1] * b[2] - a[2] * b[1];
    r[1] = a[2] * b[0] - a[0] * b[2];
    r[2] = a[0] * b[1] - a[1] * b[0];
  endfunction

  function automatic pt_out_t transform_point(input pt_in_t p);
    triple_t            src, scl, qv, v, c, t, d, off;
    longint             w, r;
    logic signed [15:0] lane [3];
    logic               sat;
    pt_out_t            res;
    int                 i;
    sat = 1'b0;
    src[0] = $signed(p.in_x);
    src[1] = $signed(p.in_y);
    src[2] = $signed(p.in_z);
    w = $signed(quat_q[63:48]);
    for (i = 0; i < 3; i++) begin
      scl[i] = $signed(scales_q[32 - 16 * i +: 16]);
      qv[i]  = $signed(quat_q[32 - 16 * i +: 16]);
      off[i] = $signed(offset_q[32 - 16 * i +: 16]);
      v[i]   = round_shift(src[i] * scl[i], 12);
    end
    cross3(qv, v, c);
    for (i = 0; i < 3; i++) t[i] = round_shift(c[i], 13);
    cross3(qv, t, d);
    for (i = 0; i < 3; i++) begin
      r = v[i] + round_shift(w * t[i] + d[i], 14);
      if (p.mode == MODE_POINT) r += off[i];
      if (r > 32767) begin
        r = 32767;
        sat = 1'b1;
      end else if (r < -32768) begin
        r = -32768;
        sat = 1'b1;
      end
      lane[i] = r[15:0];
    end
    res.out_x = lane[0];
    res.out_y = lane[1];
    res.out_z = lane[2];
    res.saturated = sat;
    return res;
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t: %s expected %0d got %0d", $time, name, $signed(want), $signed(got));
    end
  endfunction

  always @(posedge clk) begin : result_monitor
    pt_out_t want;
    if (!rst && result_valid) begin
      if (expected_points.size() == 0) begin
        mismatch_count++;
        $display("%0t: result expected none got %h", $time, result);
      end else begin
        want = expected_points.pop_front();
        check_field("out_x", want.out_x, result.out_x);
        check_field("out_y", want.out_y, result.out_y);
        check_field("out_z", want.out_z, result.out_z);
        check_field("saturated", 16'(want.saturated), 16'(result.saturated));
      end
    end
  end

  function automatic pt_in_t point_req(input logic m, input logic [15:0] x,
                                       input logic [15:0] y, input logic [15:0] z);
    pt_in_t p;
    p.mode = m;
    p.in_x = x;
    p.in_y = y;
    p.in_z = z;
    return p;
  endfunction

  function automatic logic [15:0] pick_lane(input logic [15:0] typical);
    case ($urandom_range(7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2, 3: return 16'($urandom);
      default: return typical + 16'($urandom_range(1023)) - 16'd512;
    endcase
  endfunction

  function automatic logic [15:0] pick_coord();
    case ($urandom_range(5))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2, 3: return 16'($urandom_range(4095)) - 16'd2048;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic pt_in_t random_point();
    return point_req(1'($urandom_range(1)), pick_coord(), pick_coord(), pick_coord());
  endfunction

  task automatic send_point(input pt_in_t item);
    @(negedge clk);
    if ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    start <= 1'b1;
    req <= item;
    do @(posedge clk); while (busy);
    expected_points.push_back(transform_point(item));
  endtask

  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (expected_points.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] value);
    drain();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_SCALES: scales_q = value[47:0];
      REG_QUAT:   quat_q = value;
      REG_OFFSET: offset_q = value[47:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_identity_reset();
    send_point(point_req(MODE_POINT, 16'h7FFF, 16'h8000, 16'h0000));
    send_point(point_req(MODE_DIR, 16'h8000, 16'h7FFF, 16'hFFFF));
    send_point(point_req(MODE_POINT, 16'h0100, 16'hFF00, 16'h0001));
  endtask

  task automatic test_axis_scaling();
    write_reg(REG_SCALES, 64'h7FFF_7FFF_7FFF);
    send_point(point_req(MODE_DIR, 16'h7FFF, 16'h8000, 16'h0100));
    write_reg(REG_SCALES, 64'h8000_8000_8000);
    send_point(point_req(MODE_POINT, 16'h8000, 16'h7FFF, 16'h0000));
    write_reg(REG_SCALES, 64'h0800_0800_0800);
    send_point(point_req(MODE_DIR, 16'h0001, 16'hFFFF, 16'h0003));
    send_point(point_req(MODE_POINT, 16'hFFFD, 16'h0005, 16'hFFFB));
    write_reg(REG_SCALES, 64'h0);
    send_point(point_req(MODE_POINT, 16'h7FFF, 16'h8000, 16'h1234));
    write_reg(REG_SCALES, {16'h0, SCALES_RESET});
  endtask

  task automatic test_quat_rotation();
    write_reg(REG_QUAT, 64'h2D41_0000_0000_2D41);
    send_point(point_req(MODE_DIR, 16'h0100, 16'h0000, 16'h0000));
    send_point(point_req(MODE_POINT, 16'h0000, 16'h0100, 16'h0080));
    write_reg(REG_QUAT, 64'h7FFF_7FFF_7FFF_7FFF);
    send_point(point_req(MODE_DIR, 16'h7FFF, 16'h8000, 16'h7FFF));
    write_reg(REG_QUAT, 64'h8000_8000_8000_8000);
    send_point(point_req(MODE_POINT, 16'h0001, 16'hFFFF, 16'h8000));
    write_reg(REG_QUAT, 64'h2000_2000_2000_2000);
    send_point(point_req(MODE_DIR, 16'h0003, 16'hFFFD, 16'h0001));
    write_reg(REG_QUAT, QUAT_RESET);
  endtask

  task automatic test_offset_and_mode();
    write_reg(REG_OFFSET, 64'h7FFF_8000_0001);
    send_point(point_req(MODE_POINT, 16'h0001, 16'hFFFF, 16'h0000));
    send_point(point_req(MODE_DIR, 16'h0001, 16'hFFFF, 16'h0000));
    write_reg(REG_OFFSET, 64'h8000_7FFF_FFFF);
    send_point(point_req(MODE_POINT, 16'h8000, 16'h7FFF, 16'h0000));
    send_point(point_req(MODE_DIR, 16'h8000, 16'h7FFF, 16'h0000));
  endtask

  task automatic test_register_quirks();
    write_reg(REG_NONE, {$urandom, $urandom});
    write_reg(REG_SCALES, {16'($urandom), 48'h1800_0C00_F000});
    write_reg(REG_OFFSET, {16'($urandom), 48'h0040_FFC0_0100});
    send_point(point_req(MODE_POINT, 16'h1234, 16'h8765, 16'h0F0F));
    send_point(point_req(MODE_DIR, 16'hF0F0, 16'h0321, 16'h7654));
    write_reg(REG_NONE, 64'hFFFF_FFFF_FFFF_FFFF);
    send_point(point_req(MODE_POINT, 16'h0200, 16'hFE00, 16'h0080));
  endtask

  task automatic randomize_config();
    if ($urandom_range(3) != 0)
      write_reg(REG_SCALES, {16'($urandom), pick_lane(16'h1000), pick_lane(16'h1000),
                             pick_lane(16'h1000)});
    if ($urandom_range(3) != 0)
      write_reg(REG_QUAT, {pick_lane(16'h4000), pick_lane(16'h0000), pick_lane(16'h0000),
                           pick_lane(16'h0000)});
    if ($urandom_range(3) != 0)
      write_reg(REG_OFFSET, {16'($urandom), pick_lane(16'h0000), pick_lane(16'h0000),
                             pick_lane(16'h0000)});
    if ($urandom_range(7) == 0)
      write_reg(REG_NONE, {$urandom, $urandom});
  endtask

  task automatic test_random_stream();
    int gap_list [3] = '{0, 48, 10};
    for (int ph = 0; ph < 3; ph++) begin
      gap_pct = gap_list[ph];
      for (int seg = 0; seg < 4; seg++) begin
        randomize_config();
        repeat (140) send_point(random_point());
      end
    end
    gap_pct = 0;
  endtask

  initial begin : run
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_identity_reset();
    test_axis_scaling();
    test_quat_rotation();
    test_offset_and_mode();
    test_register_quirks();
    test_random_stream();
    drain();
    repeat (LATENCY * 3) @(posedge clk);
    if (mismatch_count == 0 && expected_points.size() == 0)
      $display("tb_top: done, clean");
    else
      $display("tb_top: done, errors");
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

endmodule

/* files.f */
sv/srtp_pkg.sv
sv/srtp_scale.sv
sv/srtp_cross.sv
sv/srtp_rotate.sv
sv/srtp_clamp.sv
sv/scale_rotate_translate_point.sv
tb/tb_top.sv
